FILE: rtl/sha1_message_digest_assert.svh
// Assertion macros shared by the SHA-1 digest checker.
`ifndef SHA1_MESSAGE_DIGEST_ASSERT_SVH
`define SHA1_MESSAGE_DIGEST_ASSERT_SVH

// Consequent holds in the same cycle as the antecedent.
`define SHA1MD_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define SHA1MD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/sha1md_pkg.sv
// Types and constants of the SHA-1 message digest block.
`default_nettype none

package sha1md_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_of_message;
    } t_item;

    localparam int unsigned NUM_ROUNDS = 80;
    localparam int unsigned NUM_WORDS  = 5;
    localparam logic [2:0]  LAST_WORD_IDX = 3'd4;
    localparam logic [5:0]  LAST_BYTE_POS = 6'd63;
    localparam logic [5:0]  LEN_BYTE_POS  = 6'd56;
    localparam logic [7:0]  PAD_MARK      = 8'h80;

    localparam logic [31:0] K_0 = 32'h5A827999;
    localparam logic [31:0] K_1 = 32'h6ED9EBA1;
    localparam logic [31:0] K_2 = 32'h8F1BBCDC;
    localparam logic [31:0] K_3 = 32'hCA62C1D6;

    function automatic logic [31:0] init_chain(input logic [2:0] idx);
        logic [31:0] v;
        case (idx)
            3'd0:    v = 32'h67452301;
            3'd1:    v = 32'hEFCDAB89;
            3'd2:    v = 32'h98BADCFE;
            3'd3:    v = 32'h10325476;
            default: v = 32'hC3D2E1F0;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] round_k(input logic [6:0] t);
        logic [31:0] k;
        if (t < 7'd20) begin
            k = K_0;
        end else if (t < 7'd40) begin
            k = K_1;
        end else if (t < 7'd60) begin
            k = K_2;
        end else begin
            k = K_3;
        end
        return k;
    endfunction

    function automatic logic [31:0] round_f(input logic [6:0] t, input logic [31:0] b,
                                            input logic [31:0] c, input logic [31:0] d);
        logic [31:0] f;
        if (t < 7'd20) begin
            f = ((c ^ d) & b) ^ d;
        end else if (t >= 7'd40 && t < 7'd60) begin
            f = (b & c) | (b & d) | (c & d);
        end else begin
            f = b ^ c ^ d;
        end
        return f;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/sha1md_front.sv
// Input side of the SHA-1 block: accepts items and queues them for the core.
`default_nettype none

module sha1md_front #(
    parameter int DEPTH = 4
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_stall,
    input  wire                 i_item_in_valid,
    input  sha1md_pkg::t_item   i_item,
    output logic                o_item_valid,
    output sha1md_pkg::t_item   o_item,
    input  wire                 i_pop
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    sha1md_pkg::t_item r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          push;
    logic          pop;

    assign o_stall      = (r_count == CW'(DEPTH));
    assign push         = i_valid && i_item_in_valid && !o_stall;
    assign o_item_valid = (r_count != '0);
    assign pop          = i_pop && o_item_valid;
    assign o_item       = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/sha1md_core.sv
// Back end of the SHA-1 block: gathering, padding, compression and digest output.
`default_nettype none

module sha1md_core (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_item_valid,
    input  sha1md_pkg::t_item   i_item,
    output logic                o_pop,
    output logic                o_valid,
    input  wire                 i_stall,
    output logic [31:0]         o_digest_word,
    output logic [2:0]          o_word_index,
    output logic                o_last_word
);

    localparam logic [2:0] S_FETCH = 3'd0;
    localparam logic [2:0] S_PAD   = 3'd1;
    localparam logic [2:0] S_ROUND = 3'd2;
    localparam logic [2:0] S_ADD   = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    logic [2:0]  r_state;
    logic [31:0] r_h [sha1md_pkg::NUM_WORDS];
    logic [31:0] r_w [16];
    logic [31:0] r_a, r_b, r_c, r_d, r_e;
    logic [6:0]  r_round;
    logic [5:0]  r_fill;
    logic [63:0] r_bits;
    logic        r_eom_pend;
    logic        r_pad;
    logic        r_first;
    logic        r_len_ok;
    logic        r_final;
    logic [2:0]  r_oidx;
    logic        r_ovalid;
    logic [31:0] r_oword;
    logic [2:0]  r_oindex;
    logic        r_olast;

    logic [31:0] n_a;
    logic [31:0] n_w;
    logic [7:0]  pad_byte;
    logic        take;
    logic        out_free;

    assign o_pop    = (r_state == S_FETCH);
    assign take     = o_pop && i_item_valid;
    assign out_free = !r_ovalid || !i_stall;

    assign n_a = {r_a[26:0], r_a[31:27]} + sha1md_pkg::round_f(r_round, r_b, r_c, r_d)
                 + r_e + sha1md_pkg::round_k(r_round) + r_w[0];
    assign n_w = {r_w[13][30:0] ^ r_w[8][30:0] ^ r_w[2][30:0] ^ r_w[0][30:0],
                  r_w[13][31] ^ r_w[8][31] ^ r_w[2][31] ^ r_w[0][31]};

    always_comb begin
        if (r_first) begin
            pad_byte = sha1md_pkg::PAD_MARK;
        end else if (r_len_ok && r_fill >= sha1md_pkg::LEN_BYTE_POS) begin
            pad_byte = r_bits[{~r_fill[2:0], 3'b000} +: 8];
        end else begin
            pad_byte = 8'h00;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_FETCH && take && i_item.byte_present) begin
            r_w[r_fill[5:2]][{~r_fill[1:0], 3'b000} +: 8] <= i_item.data_byte;
        end else if (r_state == S_PAD) begin
            r_w[r_fill[5:2]][{~r_fill[1:0], 3'b000} +: 8] <= pad_byte;
        end else if (r_state == S_ROUND) begin
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= r_w[i+1];
            end
            r_w[15] <= n_w;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_FETCH;
            for (int i = 0; i < sha1md_pkg::NUM_WORDS; i++) begin
                r_h[i] <= sha1md_pkg::init_chain(3'(i));
            end
            r_fill     <= '0;
            r_bits     <= '0;
            r_round    <= '0;
            r_eom_pend <= 1'b0;
            r_pad      <= 1'b0;
            r_first    <= 1'b0;
            r_len_ok   <= 1'b0;
            r_final    <= 1'b0;
            r_oidx     <= '0;
            r_ovalid   <= 1'b0;
        end else begin
            if (r_state != S_OUT && r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_FETCH: begin
                    if (take) begin
                        if (i_item.byte_present) begin
                            r_fill <= r_fill + 1'b1;
                            r_bits <= r_bits + 64'd8;
                        end
                        if (i_item.byte_present && r_fill == sha1md_pkg::LAST_BYTE_POS) begin
                            r_eom_pend <= i_item.end_of_message;
                            r_pad      <= 1'b0;
                            r_state    <= S_ROUND;
                        end else if (i_item.end_of_message) begin
                            r_pad    <= 1'b1;
                            r_first  <= 1'b1;
                            r_len_ok <= 1'b0;
                            r_state  <= S_PAD;
                        end
                    end
                end
                S_PAD: begin
                    r_first <= 1'b0;
                    r_fill  <= r_fill + 1'b1;
                    if (r_first && r_fill < sha1md_pkg::LEN_BYTE_POS) begin
                        r_len_ok <= 1'b1;
                    end
                    if (r_fill == sha1md_pkg::LAST_BYTE_POS) begin
                        r_final <= r_len_ok;
                        r_state <= S_ROUND;
                    end
                end
                S_ROUND: begin
                    if (r_round == 7'(sha1md_pkg::NUM_ROUNDS - 1)) begin
                        r_round <= '0;
                        r_state <= S_ADD;
                    end else begin
                        r_round <= r_round + 1'b1;
                    end
                end
                S_ADD: begin
                    r_h[0] <= r_h[0] + r_a;
                    r_h[1] <= r_h[1] + r_b;
                    r_h[2] <= r_h[2] + r_c;
                    r_h[3] <= r_h[3] + r_d;
                    r_h[4] <= r_h[4] + r_e;
                    if (!r_pad) begin
                        if (r_eom_pend) begin
                            r_eom_pend <= 1'b0;
                            r_pad      <= 1'b1;
                            r_first    <= 1'b1;
                            r_len_ok   <= 1'b0;
                            r_state    <= S_PAD;
                        end else begin
                            r_state <= S_FETCH;
                        end
                    end else if (r_final) begin
                        r_oidx  <= '0;
                        r_state <= S_OUT;
                    end else begin
                        r_len_ok <= 1'b1;
                        r_state  <= S_PAD;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_ovalid <= 1'b1;
                        r_oidx   <= r_oidx + 1'b1;
                        if (r_oidx == sha1md_pkg::LAST_WORD_IDX) begin
                            for (int i = 0; i < sha1md_pkg::NUM_WORDS; i++) begin
                                r_h[i] <= sha1md_pkg::init_chain(3'(i));
                            end
                            r_fill  <= '0;
                            r_bits  <= '0;
                            r_pad   <= 1'b0;
                            r_final <= 1'b0;
                            r_state <= S_FETCH;
                        end
                    end
                end
                default: begin
                    r_state <= S_FETCH;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_FETCH && take && i_item.byte_present
             && r_fill == sha1md_pkg::LAST_BYTE_POS)
            || (r_state == S_PAD && r_fill == sha1md_pkg::LAST_BYTE_POS)) begin
            r_a <= r_h[0];
            r_b <= r_h[1];
            r_c <= r_h[2];
            r_d <= r_h[3];
            r_e <= r_h[4];
        end else if (r_state == S_ROUND) begin
            r_a <= n_a;
            r_b <= r_a;
            r_c <= {r_b[1:0], r_b[31:2]};
            r_d <= r_c;
            r_e <= r_d;
        end
        if (r_state == S_OUT && out_free) begin
            r_oword  <= r_h[r_oidx];
            r_oindex <= r_oidx;
            r_olast  <= (r_oidx == sha1md_pkg::LAST_WORD_IDX);
        end
    end

    assign o_valid       = r_ovalid;
    assign o_digest_word = r_oword;
    assign o_word_index  = r_oindex;
    assign o_last_word   = r_olast;

endmodule

`default_nettype wire

FILE: rtl/sha1_message_digest.sv
// Byte items are taken in S_FETCH; a full 64-byte block then runs 80 rounds and the add.
// End of message: padding bytes are written in S_PAD and each padded block compressed, then five
// digest words at one per cycle unless i_out_stall holds them; a single unit does every round.
// The input queue lets the front accept items while the core compresses or emits.
// Reset is synchronous and active low: it empties the queue, loads the initial chain
// constants and clears the bit count.
`default_nettype none

module sha1_message_digest #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    output logic        o_in_stall,
    input  wire  [7:0]  i_data_byte,
    input  wire         i_byte_present,
    input  wire         i_end_of_message,
    output logic        o_out_valid,
    input  wire         i_out_stall,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);

    sha1md_pkg::t_item in_item;
    sha1md_pkg::t_item q_item;
    logic              q_valid;
    logic              q_pop;

    assign in_item.data_byte      = i_data_byte;
    assign in_item.byte_present   = i_byte_present;
    assign in_item.end_of_message = i_end_of_message;

    sha1md_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_in_valid),
        .o_stall         (o_in_stall),
        .i_item_in_valid (1'b1),
        .i_item          (in_item),
        .o_item_valid    (q_valid),
        .o_item          (q_item),
        .i_pop           (q_pop)
    );

    sha1md_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_item_valid  (q_valid),
        .i_item        (q_item),
        .o_pop         (q_pop),
        .o_valid       (o_out_valid),
        .i_stall       (i_out_stall),
        .o_digest_word (o_digest_word),
        .o_word_index  (o_word_index),
        .o_last_word   (o_last_word)
    );

endmodule

`default_nettype wire

FILE: rtl/sha1md_checker.sv
// Port-level checker for the SHA-1 digest block and its bind.
`default_nettype none

`include "sha1_message_digest_assert.svh"

module sha1md_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        o_out_valid,
    input wire        i_out_stall,
    input wire [31:0] o_digest_word,
    input wire [2:0]  o_word_index,
    input wire        o_last_word
);

    `SHA1MD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_digest_word) && $stable(o_word_index), "stalled result changed")
    `SHA1MD_ASSERT_SAME(a_last_flag, i_clk, i_rst_n, o_out_valid, o_last_word == (o_word_index == 3'd4), "last flag does not match word index")
    `SHA1MD_ASSERT_SAME(a_index_range, i_clk, i_rst_n, o_out_valid, o_word_index <= 3'd4, "word index out of range")
    `SHA1MD_ASSERT_NEXT(a_word_order, i_clk, i_rst_n, o_out_valid && !i_out_stall && !o_last_word, o_out_valid && (o_word_index == $past(o_word_index) + 3'd1), "digest words not back to back in order")

endmodule

bind sha1_message_digest sha1md_checker u_sha1md_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_digest_word (o_digest_word),
    .o_word_index  (o_word_index),
    .o_last_word   (o_last_word)
);

`default_nettype wire

FILE: dv/testbench.sv
// Self-checking testbench for the SHA-1 message digest block with a digest scoreboard.
`default_nettype none

module testbench;

    typedef struct {
        logic [31:0] word;
        logic [2:0]  index;
        logic        is_last;
    } t_digest_word;

    class digest_scoreboard;
        logic [31:0]  chain_words [5];
        logic [7:0]   block_bytes [64];
        logic [63:0]  bit_count;
        t_digest_word expected_words [$];
        int           fail_count;
        int           mismatch_count;

        function new();
            fail_count     = 0;
            mismatch_count = 0;
            restart();
        endfunction

        function void restart();
            int i;
            chain_words[0] = 32'h67452301;
            chain_words[1] = 32'hEFCDAB89;
            chain_words[2] = 32'h98BADCFE;
            chain_words[3] = 32'h10325476;
            chain_words[4] = 32'hC3D2E1F0;
            for (i = 0; i < 64; i++) begin
                block_bytes[i] = 8'h00;
            end
            bit_count = 64'd0;
        endfunction

        function logic [31:0] rotl(input logic [31:0] v, input int n);
            return (v << n) | (v >> (32 - n));
        endfunction

        function void compress();
            logic [31:0] w [16];
            logic [31:0] a, b, c, d, e, f, k, tmp;
            int t;
            for (t = 0; t < 16; t++) begin
                w[t] = {block_bytes[4*t], block_bytes[4*t+1],
                        block_bytes[4*t+2], block_bytes[4*t+3]};
            end
            a = chain_words[0];
            b = chain_words[1];
            c = chain_words[2];
            d = chain_words[3];
            e = chain_words[4];
            for (t = 0; t < 80; t++) begin
                if (t >= 16) begin
                    w[t%16] = rotl(w[(t+13)%16] ^ w[(t+8)%16] ^ w[(t+2)%16] ^ w[t%16], 1);
                end
                if (t < 20) begin
                    f = ((c ^ d) & b) ^ d;
                    k = 32'h5A827999;
                end else if (t < 40) begin
                    f = b ^ c ^ d;
                    k = 32'h6ED9EBA1;
                end else if (t < 60) begin
                    f = (b & c) | (b & d) | (c & d);
                    k = 32'h8F1BBCDC;
                end else begin
                    f = b ^ c ^ d;
                    k = 32'hCA62C1D6;
                end
                tmp = rotl(a, 5) + f + e + k + w[t%16];
                e = d;
                d = c;
                c = rotl(b, 30);
                b = a;
                a = tmp;
            end
            chain_words[0] += a;
            chain_words[1] += b;
            chain_words[2] += c;
            chain_words[3] += d;
            chain_words[4] += e;
        endfunction

        function void pad_and_compress();
            logic [63:0] length_bits;
            int fill;
            int i;
            length_bits = bit_count;
            fill = int'(bit_count[8:3]);
            block_bytes[fill] = 8'h80;
            fill++;
            if (fill > 56) begin
                while (fill < 64) begin
                    block_bytes[fill] = 8'h00;
                    fill++;
                end
                compress();
                fill = 0;
            end
            while (fill < 56) begin
                block_bytes[fill] = 8'h00;
                fill++;
            end
            for (i = 0; i < 8; i++) begin
                block_bytes[56+i] = length_bits[8*(7-i) +: 8];
            end
            compress();
        endfunction

        function void note_item(input logic [7:0] data, input logic present,
                                input logic eom);
            t_digest_word dw;
            int fill;
            int i;
            if (present) begin
                fill = int'(bit_count[8:3]);
                block_bytes[fill] = data;
                bit_count += 64'd8;
                if (fill == 63) begin
                    compress();
                end
            end
            if (eom) begin
                pad_and_compress();
                for (i = 0; i < 5; i++) begin
                    dw.word    = chain_words[i];
                    dw.index   = 3'(i);
                    dw.is_last = (i == 4);
                    expected_words.push_back(dw);
                end
                restart();
            end
        endfunction

        function void check_word(input logic [31:0] word, input logic [2:0] index,
                                 input logic is_last);
            t_digest_word dw;
            if (expected_words.size() == 0) begin
                fail_count++;
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("unexpected digest transfer: word %h index %0d last %0b",
                             word, index, is_last);
                end
            end else begin
                dw = expected_words.pop_front();
                if (word !== dw.word || index !== dw.index || is_last !== dw.is_last) begin
                    fail_count++;
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("digest mismatch: expected %h/%0d/%0b, got %h/%0d/%0b",
                                 dw.word, dw.index, dw.is_last, word, index, is_last);
                    end
                end
            end
        endfunction

        function int pending();
            return expected_words.size();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic [7:0]  i_data_byte = 8'h00;
    logic        i_byte_present = 1'b0;
    logic        i_end_of_message = 1'b0;
    logic        i_out_stall = 1'b0;
    wire         o_in_stall;
    wire         o_out_valid;
    wire  [31:0] o_digest_word;
    wire  [2:0]  o_word_index;
    wire         o_last_word;

    digest_scoreboard sb;
    int  items_sent = 0;
    bit  burst_mode = 1'b0;
    bit  hold_request = 1'b0;
    int  hold_left = 0;
    int  stall_left = 0;
    bit  quiet_out = 1'b0;

    sha1_message_digest uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_data_byte      (i_data_byte),
        .i_byte_present   (i_byte_present),
        .i_end_of_message (i_end_of_message),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_digest_word    (o_digest_word),
        .o_word_index     (o_word_index),
        .o_last_word      (o_last_word)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (burst_mode || r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(5, 30);
    endfunction

    task automatic send_item(input logic [7:0] data, input logic present, input logic eom);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_data_byte      <= data;
        i_byte_present   <= present;
        i_end_of_message <= eom;
        do begin
            @(posedge i_clk);
        end while (o_in_stall !== 1'b0);
        sb.note_item(data, present, eom);
        if (present || eom) begin
            items_sent++;
        end
    endtask

    task automatic send_message(input int len, input bit end_alone);
        int i;
        for (i = 0; i < len; i++) begin
            if ($urandom_range(0, 9) == 0) begin
                send_item(8'($urandom), 1'b0, 1'b0);
            end
            send_item(8'($urandom), 1'b1, (i == len - 1) && !end_alone);
        end
        if (len == 0 || end_alone) begin
            send_item(8'($urandom), 1'b0, 1'b1);
        end
    endtask

    function automatic int pick_length();
        int r;
        int boundary [8] = '{55, 56, 57, 63, 64, 65, 119, 120};
        r = $urandom_range(0, 99);
        if (r < 35) begin
            return $urandom_range(0, 20);
        end else if (r < 75) begin
            return boundary[$urandom_range(0, 7)];
        end
        return $urandom_range(0, 140);
    endfunction

    initial begin
        sb = new();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_item(8'hFF, 1'b0, 1'b1);
        send_item(8'hA5, 1'b0, 1'b0);
        send_item(8'h00, 1'b1, 1'b1);
        send_item(8'hFF, 1'b1, 1'b1);
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'h62, 1'b1, 1'b0);
        send_item(8'h63, 1'b1, 1'b1);
        send_item(8'h12, 1'b1, 1'b0);
        send_item(8'h34, 1'b0, 1'b0);
        send_item(8'h56, 1'b1, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);
        burst_mode = 1'b1;
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'hFF, 1'b1, 1'b1);
        burst_mode = 1'b0;

        // The receiver stalls for a long stretch while messages keep arriving.
        hold_request = 1'b1;
        send_message(3, 1'b0);
        while (items_sent < 310) begin
            burst_mode = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 6) == 0) begin
                send_item(8'($urandom), 1'b0, 1'b0);
            end
            send_message(pick_length(), $urandom_range(0, 3) == 0);
        end
        i_in_valid <= 1'b0;

        while (sb.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (300) @(posedge i_clk);
        if (sb.fail_count == 0) begin
            $display("PASS sha1_message_digest");
        end else begin
            $display("FAIL sha1_message_digest");
        end
        $finish;
    end

    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
                sb.check_word(o_digest_word, o_word_index, o_last_word);
            end
            if (hold_request) begin
                hold_left    = 600;
                hold_request = 1'b0;
            end
            if ($urandom_range(0, 199) == 0) begin
                quiet_out = !quiet_out;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
                if (!quiet_out && $urandom_range(0, 3) == 0) begin
                    stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                              : $urandom_range(1, 3);
                end
            end
        end
    end

    initial begin
        #600000;
        $display("FAIL sha1_message_digest");
        $finish;
    end

endmodule

`default_nettype wire

FILE: filelist.f
+incdir+rtl
rtl/sha1md_pkg.sv
rtl/sha1md_front.sv
rtl/sha1md_core.sv
rtl/sha1_message_digest.sv
rtl/sha1md_checker.sv
dv/testbench.sv
